### hw/rtl/cartridge_bank_rtc_controller_top_macros.svh
// assertion macros for the cartridge bank controller checker
// depends on nothing; included by the checker file
`ifndef CARTRIDGE_BANK_RTC_CONTROLLER_TOP_MACROS_SVH
`define CARTRIDGE_BANK_RTC_CONTROLLER_TOP_MACROS_SVH

// clocked property with asynchronous active-low reset
`define CBRTC_ASSERT(label, clk_sig, rst_n_sig, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error("cbrtc checker: property violated");

// same, on the block clock and reset
`define CBRTC_ASSERT_CLK(label, prop) `CBRTC_ASSERT(label, clk, arst_n, prop)

`endif

### hw/rtl/cbrtc_pkg.sv
// types and constants of the cartridge bank controller with clock
// no dependencies; used by every other file of the block but the macro header
package cbrtc_pkg;

	// request kinds
	typedef logic [1:0] req_type_t;
	localparam req_type_t REQ_WRITE = 2'd0;
	localparam req_type_t REQ_READ  = 2'd1;
	localparam req_type_t REQ_TICK  = 2'd2;

	// access targets
	typedef logic [2:0] target_t;
	localparam target_t TGT_NONE     = 3'd0;
	localparam target_t TGT_ROM      = 3'd1;
	localparam target_t TGT_RAM      = 3'd2;
	localparam target_t TGT_REG      = 3'd3;
	localparam target_t TGT_UNMAPPED = 3'd4;

	// upper window modes
	typedef logic [1:0] win_mode_t;
	localparam win_mode_t WIN_OFF   = 2'd0;
	localparam win_mode_t WIN_RAM   = 2'd1;
	localparam win_mode_t WIN_CLOCK = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_RTC_CRYSTAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROTECTION  = 1'b1;

	// control area slices, address bits 14:13
	localparam logic [1:0] AREA_ENABLE    = 2'd0;
	localparam logic [1:0] AREA_LOW_BANK  = 2'd1;
	localparam logic [1:0] AREA_HIGH_BANK = 2'd2;
	localparam logic [1:0] AREA_LATCH     = 2'd3;

	// window at 0xa000-0xbfff: address bits 15:13
	localparam logic [2:0] WINDOW_PAGE = 3'b101;
	localparam logic [3:0] WIN_EN_KEY  = 4'ha;

	// window register indexes
	typedef logic [2:0] reg_sel_t;
	localparam int TIME_REGS = 5;
	localparam reg_sel_t REG_SEC      = 3'd0;
	localparam reg_sel_t REG_MIN      = 3'd1;
	localparam reg_sel_t REG_HOUR     = 3'd2;
	localparam reg_sel_t REG_DAY_LOW  = 3'd3;
	localparam reg_sel_t REG_CTRL     = 3'd4;
	localparam reg_sel_t REG_PROT_CMD = 3'd7;

	// time masks and rollover patterns
	localparam logic [7:0] SEC_MASK     = 8'h3f;
	localparam logic [7:0] SEC_ROLL     = 8'h3c;
	localparam logic [7:0] HOUR_MASK    = 8'h1f;
	localparam logic [7:0] HOUR_ROLL    = 8'h18;
	localparam logic [7:0] CTRL_WR_MASK = 8'hc1;
	localparam int CTRL_OVF_BIT  = 7;
	localparam int CTRL_HALT_BIT = 6;
	localparam int CTRL_DAY8_BIT = 0;

	typedef logic [TIME_REGS-1:0][7:0] time_regs_t;
	localparam time_regs_t LIVE_RESET = {8'hc1, 8'hff, 8'h1f, 8'h3f, 8'h3f};

	// protection commands
	localparam logic [7:0] CMD_DEC_0 = 8'h11;
	localparam logic [7:0] CMD_DEC_1 = 8'h12;
	localparam logic [7:0] CMD_ADD_0 = 8'h41;
	localparam logic [7:0] CMD_ADD_1 = 8'h42;
	localparam logic [7:0] CMD_INC_0 = 8'h51;
	localparam logic [7:0] CMD_INC_1 = 8'h52;

	localparam logic [6:0] LOW_BANK_RESET = 7'd1;

	typedef logic [1:0][7:0] prot_vals_t;

	// window register write
	typedef struct packed {
		logic       en;
		reg_sel_t   sel;
		logic [7:0] data;
	} win_wr_t;

	// control of the time registers
	typedef struct packed {
		logic    tick;
		logic    latch;
		win_wr_t wr;
	} time_ctl_t;

endpackage

### hw/rtl/cbrtc_if.sv
// request and result channels of the cartridge bank controller
// depends on cbrtc_pkg
interface cbrtc_req_if;
	import cbrtc_pkg::*;
	logic       valid;
	logic       ready;
	req_type_t  req_type;
	logic [15:0] address;
	logic [7:0] write_data;

	modport source (output valid, output req_type, output address, output write_data,
		input ready);
	modport sink (input valid, input req_type, input address, input write_data,
		output ready);
endinterface

interface cbrtc_res_if;
	import cbrtc_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	target_t    access_target;
	logic [6:0] rom_bank_low;
	logic [2:0] bank_high;
	win_mode_t  window_mode;

	modport source (output valid, output read_data, output access_target,
		output rom_bank_low, output bank_high, output window_mode, input ready);
	modport sink (input valid, input read_data, input access_target,
		input rom_bank_low, input bank_high, input window_mode, output ready);
endinterface

### hw/rtl/cbrtc_time.sv
// live and latched clock registers: tick carry chain, writes, latch copy
// depends on cbrtc_pkg
module cbrtc_time (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cbrtc_pkg::time_ctl_t   ctl,
	input  cbrtc_pkg::reg_sel_t    rd_sel,
	output logic [7:0]             rd_data
);
	import cbrtc_pkg::*;

	time_regs_t live_q;
	time_regs_t latched_q;

	logic [7:0] sec_nx, min_nx, hour_nx, day_nx, ctrl_nx;
	logic [7:0] sec_inc, min_inc, hour_inc;
	logic       sec_c, min_c, hour_c, day_c;
	logic       run;

	// each unit wraps to zero on its rollover pattern and carries on zero
	always_comb begin
		sec_inc  = 8'(live_q[REG_SEC] + 8'd1) & SEC_MASK;
		sec_nx   = ((sec_inc & SEC_ROLL) == SEC_ROLL) ? 8'd0 : sec_inc;
		sec_c    = (sec_nx == 8'd0);
		min_inc  = 8'(live_q[REG_MIN] + 8'd1) & SEC_MASK;
		min_nx   = ((min_inc & SEC_ROLL) == SEC_ROLL) ? 8'd0 : min_inc;
		min_c    = (min_nx == 8'd0);
		hour_inc = 8'(live_q[REG_HOUR] + 8'd1) & HOUR_MASK;
		hour_nx  = ((hour_inc & HOUR_ROLL) == HOUR_ROLL) ? 8'd0 : hour_inc;
		hour_c   = (hour_nx == 8'd0);
		day_nx   = 8'(live_q[REG_DAY_LOW] + 8'd1);
		day_c    = (day_nx == 8'd0);
		ctrl_nx  = live_q[REG_CTRL];
		if (live_q[REG_CTRL][CTRL_DAY8_BIT]) begin
			ctrl_nx[CTRL_OVF_BIT] = 1'b1;
		end
		ctrl_nx[CTRL_DAY8_BIT] = ~live_q[REG_CTRL][CTRL_DAY8_BIT];
		run = ctl.tick && !live_q[REG_CTRL][CTRL_HALT_BIT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= LIVE_RESET;
			latched_q <= '0;
		end else begin
			if (ctl.latch) begin
				latched_q <= live_q;
			end
			if (run) begin
				live_q[REG_SEC] <= sec_nx;
				if (sec_c) begin
					live_q[REG_MIN] <= min_nx;
					if (min_c) begin
						live_q[REG_HOUR] <= hour_nx;
						if (hour_c) begin
							live_q[REG_DAY_LOW] <= day_nx;
							if (day_c) begin
								live_q[REG_CTRL] <= ctrl_nx;
							end
						end
					end
				end
			end else if (ctl.wr.en) begin
				case (ctl.wr.sel)
					REG_SEC:     live_q[REG_SEC]     <= ctl.wr.data;
					REG_MIN:     live_q[REG_MIN]     <= ctl.wr.data;
					REG_HOUR:    live_q[REG_HOUR]    <= ctl.wr.data;
					REG_DAY_LOW: live_q[REG_DAY_LOW] <= ctl.wr.data;
					REG_CTRL:    live_q[REG_CTRL]    <= ctl.wr.data & CTRL_WR_MASK;
					default: ;
				endcase
			end
		end
	end

	// reads see the latched copy
	always_comb begin
		case (rd_sel)
			REG_SEC:     rd_data = latched_q[REG_SEC];
			REG_MIN:     rd_data = latched_q[REG_MIN];
			REG_HOUR:    rd_data = latched_q[REG_HOUR];
			REG_DAY_LOW: rd_data = latched_q[REG_DAY_LOW];
			REG_CTRL:    rd_data = latched_q[REG_CTRL];
			default:     rd_data = 8'd0;
		endcase
	end

endmodule

### hw/rtl/cbrtc_prot.sv
// protection value pair with its command port (window registers 5 to 7)
// depends on cbrtc_pkg
module cbrtc_prot (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cbrtc_pkg::win_wr_t    wr,
	output cbrtc_pkg::prot_vals_t vals
);
	import cbrtc_pkg::*;

	prot_vals_t vals_q;
	logic       k;

	assign k    = wr.data[0];
	assign vals = vals_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vals_q <= '0;
		end else if (wr.en) begin
			if (wr.sel == REG_PROT_CMD) begin
				case (wr.data)
					CMD_DEC_0, CMD_DEC_1: vals_q[k] <= 8'(vals_q[k] - 8'd1);
					CMD_ADD_0, CMD_ADD_1: vals_q[k] <= 8'(vals_q[k] + vals_q[~k]);
					CMD_INC_0, CMD_INC_1: vals_q[k] <= 8'(vals_q[k] + 8'd1);
					default: ;
				endcase
			end else begin
				// register 5 holds value 1, register 6 value 0
				vals_q[wr.sel[0]] <= wr.data;
			end
		end
	end

endmodule

### hw/rtl/cartridge_bank_rtc_controller_top.sv
// cartridge bank controller with clock: an accepted request goes into the input register
// and then the result register; throughput one request per cycle without output stall
// since the whole update sits between the input register and the result register;
// under output stall the input register holds one more request
// reset: asynchronous active low, clock registers return to their cold values
// depends on cbrtc_pkg, cbrtc_if, cbrtc_time and cbrtc_prot
module cartridge_bank_rtc_controller_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	cbrtc_req_if.sink                            req,
	cbrtc_res_if.source                          res,
	input  logic                                 cfg_we,
	input  logic [cbrtc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cbrtc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import cbrtc_pkg::*;

	// configuration
	logic rtc_crystal_q;
	logic prot_present_q;

	// input stage
	logic        valid_s1;
	req_type_t   req_type_s1;
	logic [15:0] address_s1;
	logic [7:0]  write_data_s1;
	logic        in_acc;
	logic        adv;

	// bank and window control state
	logic       win_en_q;
	logic [3:0] win_sel_q;
	logic       latch_prev_q;
	logic [6:0] low_bank_q;
	logic [2:0] high_bank_q;

	// next values, shown in the result after the update
	logic       win_en_nx;
	logic [3:0] win_sel_nx;
	logic [6:0] low_bank_nx;
	logic [2:0] high_bank_nx;
	logic       latch_prev_nx;
	win_mode_t  mode_cur, mode_nx;

	// decode
	logic       is_write, is_read, is_ctrl, in_win, reg_ok, win_reg_hit;
	reg_sel_t   reg_sel;
	target_t    target;
	logic [7:0] rd_data;
	logic [7:0] time_rd;
	prot_vals_t prot_vals;
	time_ctl_t  time_ctl;
	win_wr_t    prot_wr;
	logic       do_latch;

	// result register
	logic       res_valid_q;
	logic [7:0] read_data_q;
	target_t    target_q;
	logic [6:0] rom_bank_low_q;
	logic [2:0] bank_high_q;
	win_mode_t  mode_q;

	// configuration writes land at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtc_crystal_q  <= 1'b1;
			prot_present_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RTC_CRYSTAL: rtc_crystal_q  <= cfg_wdata[0];
				CFG_PROTECTION:  prot_present_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// input register: takes a request when empty or whenever the held one moves on this cycle
	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || adv;
	assign in_acc    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_type_s1   <= req.req_type;
			address_s1    <= req.address;
			write_data_s1 <= req.write_data;
		end
	end

	// address decode on the held request
	assign is_write = (req_type_s1 == REQ_WRITE);
	assign is_read  = (req_type_s1 == REQ_READ);
	assign is_ctrl  = !address_s1[15];
	assign in_win   = (address_s1[15:13] == WINDOW_PAGE);
	assign reg_sel  = win_sel_q[2:0];
	assign reg_ok   = (reg_sel < 3'(TIME_REGS)) || prot_present_q;
	assign mode_cur = !win_en_q ? WIN_OFF : (win_sel_q[3] ? WIN_CLOCK : WIN_RAM);
	assign win_reg_hit = in_win && (mode_cur == WIN_CLOCK) && reg_ok;

	// access target for reads and writes; tick and the unused code give none
	always_comb begin
		target = TGT_NONE;
		if (is_write || is_read) begin
			if (is_ctrl) begin
				target = is_read ? TGT_ROM : TGT_NONE;
			end else if (in_win) begin
				case (mode_cur)
					WIN_OFF:   target = TGT_UNMAPPED;
					WIN_RAM:   target = TGT_RAM;
					WIN_CLOCK: target = reg_ok ? TGT_REG : TGT_UNMAPPED;
					default:   target = TGT_UNMAPPED;
				endcase
			end else begin
				target = TGT_UNMAPPED;
			end
		end
	end

	// window register read: latched clock, protection values, command port reads 0
	always_comb begin
		rd_data = 8'd0;
		if (is_read && win_reg_hit) begin
			if (reg_sel < 3'(TIME_REGS)) begin
				rd_data = time_rd;
			end else if (reg_sel != REG_PROT_CMD) begin
				rd_data = prot_vals[reg_sel[0]];
			end
		end
	end

	// control area writes, one job per 8 KiB slice
	always_comb begin
		win_en_nx     = win_en_q;
		win_sel_nx    = win_sel_q;
		low_bank_nx   = low_bank_q;
		high_bank_nx  = high_bank_q;
		latch_prev_nx = latch_prev_q;
		do_latch      = 1'b0;
		if (is_write && is_ctrl) begin
			case (address_s1[14:13])
				AREA_ENABLE:    win_en_nx = (write_data_s1[3:0] == WIN_EN_KEY);
				AREA_LOW_BANK:  low_bank_nx = (write_data_s1[6:0] == 7'd0) ?
					LOW_BANK_RESET : write_data_s1[6:0];
				AREA_HIGH_BANK: begin
					high_bank_nx = write_data_s1[2:0];
					win_sel_nx   = write_data_s1[3:0];
				end
				AREA_LATCH: begin
					// copy on a rising edge of data bit 0
					do_latch      = !latch_prev_q && write_data_s1[0];
					latch_prev_nx = write_data_s1[0];
				end
				default: ;
			endcase
		end
		mode_nx = !win_en_nx ? WIN_OFF : (win_sel_nx[3] ? WIN_CLOCK : WIN_RAM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_en_q     <= 1'b0;
			win_sel_q    <= 4'd0;
			latch_prev_q <= 1'b0;
			low_bank_q   <= LOW_BANK_RESET;
			high_bank_q  <= 3'd0;
		end else if (adv) begin
			win_en_q     <= win_en_nx;
			win_sel_q    <= win_sel_nx;
			latch_prev_q <= latch_prev_nx;
			low_bank_q   <= low_bank_nx;
			high_bank_q  <= high_bank_nx;
		end
	end

	// clock register control; updates only when the request moves on
	always_comb begin
		time_ctl.tick    = adv && (req_type_s1 == REQ_TICK) && rtc_crystal_q;
		time_ctl.latch   = adv && do_latch;
		time_ctl.wr.en   = adv && is_write && win_reg_hit && (reg_sel < 3'(TIME_REGS));
		time_ctl.wr.sel  = reg_sel;
		time_ctl.wr.data = write_data_s1;
		prot_wr.en       = adv && is_write && win_reg_hit && (reg_sel >= 3'(TIME_REGS));
		prot_wr.sel      = reg_sel;
		prot_wr.data     = write_data_s1;
	end

	cbrtc_time u_time (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (time_ctl),
		.rd_sel  (reg_sel),
		.rd_data (time_rd)
	);

	cbrtc_prot u_prot (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (prot_wr),
		.vals   (prot_vals)
	);

	// result register, holds under output stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= adv || (res_valid_q && !res.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q    <= rd_data;
			target_q       <= target;
			rom_bank_low_q <= low_bank_nx;
			bank_high_q    <= high_bank_nx;
			mode_q         <= mode_nx;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.read_data     = read_data_q;
	assign res.access_target = target_q;
	assign res.rom_bank_low  = rom_bank_low_q;
	assign res.bank_high     = bank_high_q;
	assign res.window_mode   = mode_q;

endmodule

### hw/rtl/cbrtc_checker.sv
// port-level checks on the result channel of the cartridge bank controller
// depends on cbrtc_pkg and the assertion macro header; bound to the top level
`include "cartridge_bank_rtc_controller_top_macros.svh"

module cbrtc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [7:0]           read_data,
	input cbrtc_pkg::target_t   access_target,
	input logic [6:0]           rom_bank_low,
	input cbrtc_pkg::win_mode_t window_mode
);
	import cbrtc_pkg::*;

	logic [19:0] res_payload;
	logic        win_hit;

	assign res_payload = {read_data, access_target, rom_bank_low, window_mode};
	assign win_hit     = (access_target == TGT_RAM) || (access_target == TGT_REG);

	// a stalled result keeps its payload
	`CBRTC_ASSERT_CLK(a_stall_hold, res_valid && !res_ready |=> res_valid && $stable(res_payload))

	// the low bank never maps page zero
	`CBRTC_ASSERT_CLK(a_bank_nonzero, res_valid |-> rom_bank_low != 7'd0)

	// only a register read returns data
	`CBRTC_ASSERT_CLK(a_data_only_reg, res_valid && (read_data != 8'd0) |-> access_target == TGT_REG)

	// a closed window never reaches RAM or registers
	`CBRTC_ASSERT_CLK(a_closed_window, res_valid && (window_mode == WIN_OFF) |-> !win_hit)

endmodule

bind cartridge_bank_rtc_controller_top cbrtc_checker u_cbrtc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.read_data     (res.read_data),
	.access_target (res.access_target),
	.rom_bank_low  (res.rom_bank_low),
	.window_mode   (res.window_mode)
);
